[rtl/dbcs_pkg.sv]
// dbcs_pkg: shared types, widths and codes for the depth box centroid steer block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package dbcs_pkg;
	localparam int MaxColumns = 1024;
	localparam int MaxRows    = 1024;
	localparam int ColW = $clog2(MaxColumns);
	localparam int RowW = $clog2(MaxRows);

	localparam logic [1:0] CMD_PIXEL   = 2'd0;
	localparam logic [1:0] CMD_COL_SIN = 2'd1;
	localparam logic [1:0] CMD_ROW_SIN = 2'd2;

	localparam logic [1:0] ACT_FEW    = 2'd0;
	localparam logic [1:0] ACT_INVITE = 2'd1;
	localparam logic [1:0] ACT_FAR    = 2'd2;
	localparam logic [1:0] ACT_TURN   = 2'd3;

	localparam logic [2:0] REG_MIN_X = 3'd0;
	localparam logic [2:0] REG_MAX_X = 3'd1;
	localparam logic [2:0] REG_MIN_Y = 3'd2;
	localparam logic [2:0] REG_MAX_Y = 3'd3;
	localparam logic [2:0] REG_NEAR  = 3'd4;
	localparam logic [2:0] REG_FAR   = 3'd5;
	localparam logic [2:0] REG_MINPT = 3'd6;
	localparam logic [2:0] REG_GAIN  = 3'd7;

	typedef struct packed {
		logic signed [12:0] min_x;
		logic signed [12:0] max_x;
		logic signed [12:0] min_y;
		logic signed [12:0] max_y;
		logic [15:0]        near_lim;
		logic [15:0]        far_lim;
		logic [19:0]        min_pts;
		logic [7:0]         gain;
	} cfg_t;

	// controller to datapath
	typedef struct packed {
		logic pix_go;     // pixel accepted, start projection
		logic frame_end;  // pixel of this go closes the frame
		logic div_start;  // start mean division
		logic div_step;   // one quotient bit
		logic decide;     // compute decision and load output
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic acc_done;   // last pixel folded into accumulators
		logic div_last;   // final quotient bit this cycle
	} dp_sts_t;

	typedef struct packed {
		logic [1:0]         action;
		logic signed [15:0] rate;
		logic [15:0]        nearest;
		logic signed [12:0] mean;
		logic [19:0]        points;
		logic               waiting;
	} result_t;
endpackage
`default_nettype wire

[rtl/depth_box_centroid_steer_core.sv]
// depth_box_centroid_steer_core: top level, config registers, controller and datapath
// depends on dbcs_pkg, dbcs_ctrl, dbcs_datapath
//
// usage:
//   s_axis carries pixel and sine-table load transactions; a pixel with
//   frame_last set closes the frame. m_axis carries one decision per frame.
//   cfg_we/cfg_addr/cfg_wdata write the eight box and limit registers; write
//   only while idle.
// throughput and frame-end sequence:
//   one pixel or table load per cycle within a frame. the frame-closing pixel
//   passes a two-stage projection pipe (table read, multiply) and the
//   accumulate stage, then a bit-serial signed division of the offset sum by
//   the count runs, and a decision state loads the result for m_axis_tvalid.
//   intake pauses from the accepting edge of the last pixel until the result
//   is taken.
// reset:
//   arst_n clears accumulators (nearest to 65535), the wait flag and config
//   to defaults. sine tables are not cleared and must be loaded first.
// stall:
//   while a result waits on m_axis_tready the next transaction is accepted
//   in the same cycle the result leaves; otherwise s_axis_tready stays low.
`timescale 1ns / 1ps
`default_nettype none
module depth_box_centroid_steer_core import dbcs_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// tdata: cmd[1:0] column[11:2] row[21:12] sine_value[37:22] depth_mm[53:38]
	//        depth_valid[54], zero pad to 56
	input  wire logic [55:0] s_axis_tdata,
	input  wire logic        s_axis_tlast,   // frame_last
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// tdata: action[1:0] angular_rate_mrad[17:2] nearest_mm[33:18]
	//        mean_offset_mm[46:34] points_in_box[66:47] waiting[67], pad to 72
	output logic [71:0]      m_axis_tdata,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_addr,
	input  wire logic [19:0] cfg_wdata
);
	cfg_t cfg_q;
	dp_cmd_t dcmd;
	dp_sts_t sts;
	result_t res;

	// field unpack
	wire [1:0]  cmd         = s_axis_tdata[1:0];
	wire [9:0]  column      = s_axis_tdata[11:2];
	wire [9:0]  row         = s_axis_tdata[21:12];
	wire [15:0] sine_value  = s_axis_tdata[37:22];
	wire [15:0] depth_mm    = s_axis_tdata[53:38];
	wire        depth_valid = s_axis_tdata[54];
	wire in_fire = s_axis_tvalid && s_axis_tready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_x <= -13'sd200;
			cfg_q.max_x <= 13'sd200;
			cfg_q.min_y <= 13'sd100;
			cfg_q.max_y <= 13'sd500;
			cfg_q.near_lim <= 16'd600;
			cfg_q.far_lim <= 16'd2000;
			cfg_q.min_pts <= 20'd4000;
			cfg_q.gain <= 8'd10;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MIN_X: cfg_q.min_x <= cfg_wdata[12:0];
				REG_MAX_X: cfg_q.max_x <= cfg_wdata[12:0];
				REG_MIN_Y: cfg_q.min_y <= cfg_wdata[12:0];
				REG_MAX_Y: cfg_q.max_y <= cfg_wdata[12:0];
				REG_NEAR: cfg_q.near_lim <= cfg_wdata[15:0];
				REG_FAR: cfg_q.far_lim <= cfg_wdata[15:0];
				REG_MINPT: cfg_q.min_pts <= cfg_wdata;
				REG_GAIN: cfg_q.gain <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	dbcs_ctrl u_ctrl (
		.clk, .arst_n, .in_fire, .cmd, .frame_last(s_axis_tlast),
		.out_ready(m_axis_tready), .sts, .dcmd,
		.in_ready(s_axis_tready), .out_valid(m_axis_tvalid)
	);

	dbcs_datapath u_dp (
		.clk, .arst_n, .cfg(cfg_q), .cmd, .in_fire, .column, .row, .sine_value,
		.depth_mm, .depth_valid, .dcmd, .sts, .res
	);

	assign m_axis_tdata = {4'd0, res.waiting, res.points, res.mean, res.nearest,
		res.rate, res.action};

	// intake must stay closed while a decision result is stalled
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
		else $error("intake open while result stalled");
	// a non-turn decision carries zero rate
	a_rate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[1:0] != ACT_TURN |-> m_axis_tdata[17:2] == 16'd0)
		else $error("nonzero rate on stop decision");
	// frame-closing pixel closes intake on the next cycle
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && cmd == CMD_PIXEL && s_axis_tlast |=> !s_axis_tready)
		else $error("intake still open after frame end");
endmodule
`default_nettype wire

[rtl/dbcs_datapath.sv]
// dbcs_datapath: sine tables, projection pipeline, accumulators, serial divider, decision
// depends on dbcs_pkg
`timescale 1ns / 1ps
`default_nettype none
module dbcs_datapath import dbcs_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cfg_t          cfg,
	input  wire logic [1:0]    cmd,
	input  wire logic          in_fire,
	input  wire logic [9:0]    column,
	input  wire logic [9:0]    row,
	input  wire logic [15:0]   sine_value,
	input  wire logic [15:0]   depth_mm,
	input  wire logic          depth_valid,
	input  wire dp_cmd_t       dcmd,
	output dp_sts_t            sts,
	output result_t            res
);
	logic signed [15:0] col_mem [MaxColumns];
	logic signed [15:0] row_mem [MaxRows];
	logic signed [15:0] csin_s1, rsin_s1;
	logic [15:0] depth_s1;
	logic use_s1, last_s1;
	logic signed [32:0] px_s2, py_s2;
	logic [15:0] depth_s2;
	logic use_s2, last_s2;
	logic last_s3;
	logic signed [33:0] sum_q;
	logic [19:0] cnt_q;
	logic [15:0] near_q;
	logic wait_q;
	logic [33:0] rem_q, quo_q;
	logic [33:0] dvd_q;
	logic neg_q;
	logic [5:0] bit_q;

	wire col_ok = ({1'b0, column} < 11'(MaxColumns));
	wire rtab_ok = ({1'b0, column} < 11'(MaxRows));
	wire row_ok = ({1'b0, row} < 11'(MaxRows));

	always_ff @(posedge clk) begin
		if (in_fire && cmd == CMD_COL_SIN && col_ok) col_mem[column[ColW-1:0]] <= sine_value;
		if (in_fire && cmd == CMD_ROW_SIN && rtab_ok) row_mem[column[RowW-1:0]] <= sine_value;
		csin_s1 <= col_mem[column[ColW-1:0]];
		rsin_s1 <= row_mem[row[RowW-1:0]];
		depth_s1 <= depth_mm;
		px_s2 <= csin_s1 * $signed({1'b0, depth_s1});
		py_s2 <= rsin_s1 * $signed({1'b0, depth_s1});
		depth_s2 <= depth_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			use_s1 <= 1'b0; last_s1 <= 1'b0; use_s2 <= 1'b0; last_s2 <= 1'b0;
			last_s3 <= 1'b0;
		end else begin
			use_s1 <= dcmd.pix_go && depth_valid && depth_mm <= cfg.far_lim && col_ok && row_ok;
			last_s1 <= dcmd.pix_go && dcmd.frame_end;
			use_s2 <= use_s1;
			last_s2 <= last_s1;
			// accumulators hold the closing pixel in the cycle after last_s2
			last_s3 <= last_s2;
		end
	end

	// box test, strict on all sides; bounds scaled by 2^15
	wire signed [33:0] bminx = 34'(cfg.min_x) <<< 15;
	wire signed [33:0] bmaxx = 34'(cfg.max_x) <<< 15;
	wire signed [33:0] bminy = 34'(cfg.min_y) <<< 15;
	wire signed [33:0] bmaxy = 34'(cfg.max_y) <<< 15;
	wire in_box = (34'(py_s2) > bminy) && (34'(py_s2) < bmaxy)
		&& (34'(px_s2) > bminx) && (34'(px_s2) < bmaxx);
	wire signed [33:0] xr = 34'(px_s2) + 34'sd16384;
	wire signed [18:0] xmm = xr[33:15];
	wire signed [34:0] nsum = 35'(sum_q) + 35'(xmm);
	logic signed [33:0] sat_sum;
	always_comb begin
		if (nsum[34] != nsum[33]) sat_sum = nsum[34] ? {1'b1, 33'd0} : {1'b0, {33{1'b1}}};
		else sat_sum = nsum[33:0];
	end
	wire hit = use_s2 && in_box;
	wire [33:0] sum_abs = sum_q[33] ? 34'(-sum_q) : sum_q;
	wire [34:0] trial = {rem_q, dvd_q[33]} - {15'd0, cnt_q};

	// mean and rate
	logic signed [34:0] qs;
	logic signed [12:0] mean_c;
	logic signed [23:0] prod;
	logic signed [15:0] rate_c;
	logic [1:0] act_c;
	logic wait_c;
	always_comb begin
		qs = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
		if (cnt_q == 20'd0) mean_c = '0;
		else if (qs > 35'sd4095) mean_c = 13'sd4095;
		else if (qs < -35'sd4096) mean_c = -13'sd4096;
		else mean_c = qs[12:0];
		prod = -(24'(mean_c) * $signed({1'b0, cfg.gain}));
		if (prod > 24'sd32767) rate_c = 16'sd32767;
		else if (prod < -24'sd32768) rate_c = -16'sd32768;
		else rate_c = prod[15:0];
		wait_c = wait_q;
		if (cnt_q > cfg.min_pts) begin
			if (near_q <= cfg.near_lim && !wait_q) begin
				act_c = ACT_INVITE; wait_c = 1'b1;
			end else if (near_q > cfg.far_lim) begin
				act_c = ACT_FAR; wait_c = 1'b0;
			end else begin
				act_c = ACT_TURN;
			end
		end else begin
			act_c = ACT_FEW;
		end
		if (act_c != ACT_TURN) rate_c = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0; cnt_q <= '0; near_q <= '1; wait_q <= 1'b0; bit_q <= '0;
		end else begin
			if (dcmd.decide) begin
				wait_q <= wait_c;
				sum_q <= '0; cnt_q <= '0; near_q <= '1;
			end else if (hit) begin
				sum_q <= sat_sum;
				if (cnt_q != '1) cnt_q <= cnt_q + 20'd1;
				if (depth_s2 < near_q) near_q <= depth_s2;
			end
			if (dcmd.div_start) bit_q <= 6'd33;
			else if (dcmd.div_step && bit_q != 6'd0) bit_q <= bit_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (dcmd.div_start) begin
			dvd_q <= sum_abs; neg_q <= sum_q[33]; rem_q <= '0; quo_q <= '0;
		end else if (dcmd.div_step) begin
			dvd_q <= {dvd_q[32:0], 1'b0};
			if (!trial[34]) begin
				rem_q <= trial[33:0]; quo_q <= {quo_q[32:0], 1'b1};
			end else begin
				rem_q <= {rem_q[32:0], dvd_q[33]}; quo_q <= {quo_q[32:0], 1'b0};
			end
		end
		if (dcmd.decide) begin
			res.action <= act_c; res.rate <= rate_c; res.nearest <= near_q;
			res.mean <= mean_c; res.points <= cnt_q; res.waiting <= wait_c;
		end
	end

	assign sts.acc_done = last_s3;
	assign sts.div_last = dcmd.div_step && bit_q == 6'd0;
endmodule
`default_nettype wire

[rtl/dbcs_ctrl.sv]
// dbcs_ctrl: sequencer for pixel intake, frame-end division and result handoff
// depends on dbcs_pkg
`timescale 1ns / 1ps
`default_nettype none
module dbcs_ctrl import dbcs_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_fire,
	input  wire logic [1:0] cmd,
	input  wire logic    frame_last,
	input  wire logic    out_ready,
	input  wire dp_sts_t sts,
	output dp_cmd_t      dcmd,
	output logic         in_ready,
	output logic         out_valid
);
	typedef enum logic [2:0] {ST_RUN, ST_DRAIN, ST_DIV, ST_DECIDE, ST_OUT} state_t;
	state_t state_q;

	wire pix = in_fire && cmd == CMD_PIXEL;
	always_comb begin
		dcmd = '0;
		dcmd.pix_go = pix;
		dcmd.frame_end = frame_last;
		dcmd.div_start = (state_q == ST_DRAIN) && sts.acc_done;
		dcmd.div_step = state_q == ST_DIV;
		dcmd.decide = state_q == ST_DECIDE;
	end
	assign in_ready = (state_q == ST_RUN) || (state_q == ST_OUT && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN; out_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_RUN: if (pix && frame_last) state_q <= ST_DRAIN;
				ST_DRAIN: if (sts.acc_done) state_q <= ST_DIV;
				ST_DIV: if (sts.div_last) state_q <= ST_DECIDE;
				ST_DECIDE: begin
					state_q <= ST_OUT; out_valid <= 1'b1;
				end
				ST_OUT: if (out_ready) begin
					out_valid <= 1'b0;
					state_q <= (pix && frame_last) ? ST_DRAIN : ST_RUN;
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end
endmodule
`default_nettype wire

[test/tb_top.sv]
// tb_top: self-checking bench for depth_box_centroid_steer_core
// depends on dbcs_pkg and depth_box_centroid_steer_core
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	import dbcs_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [55:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [71:0] m_axis_tdata;
	logic        cfg_we;
	logic [2:0]  cfg_addr;
	logic [19:0] cfg_wdata;

	depth_box_centroid_steer_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	// 10 ns clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// shadow of the block's configuration and frame state
	logic signed [12:0] sh_min_x, sh_max_x, sh_min_y, sh_max_y;
	logic [15:0]        sh_near, sh_far;
	logic [19:0]        sh_min_pts;
	logic [7:0]         sh_gain;
	logic signed [15:0] col_sine [MaxColumns];
	logic signed [15:0] row_sine [MaxRows];
	longint             frame_sum;
	int unsigned        frame_points;
	int unsigned        frame_nearest;
	bit                 wait_flag;

	result_t     decision_queue [$];
	int          error_count;
	longint      cycle_count;
	int          send_idle_pct;
	int          recv_stall_pct;
	int          hold_off_cycles;
	int          decisions_seen;

	localparam longint CycleLimit = 3_000_000;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d (cycle %0d)", what, got, want, cycle_count);
		error_count++;
	endtask

	function automatic void shadow_reset();
		sh_min_x = -13'sd200;
		sh_max_x = 13'sd200;
		sh_min_y = 13'sd100;
		sh_max_y = 13'sd500;
		sh_near = 16'd600;
		sh_far = 16'd2000;
		sh_min_pts = 20'd4000;
		sh_gain = 8'd10;
		frame_sum = 0;
		frame_points = 0;
		frame_nearest = 65535;
		wait_flag = 1'b0;
	endfunction

	// predict the effect of one accepted transaction, queue a decision at frame end
	function automatic void predict_item(input logic [1:0] cmd, input int col, input int row,
			input logic signed [15:0] sine, input int unsigned depth, input bit valid,
			input bit last);
		longint px, py, xmm, mean, rate;
		result_t r;
		if (cmd == CMD_COL_SIN) begin
			col_sine[col] = sine;
			return;
		end
		if (cmd == CMD_ROW_SIN) begin
			row_sine[col] = sine;
			return;
		end
		if (cmd != CMD_PIXEL)
			return;
		if (valid && depth <= sh_far) begin
			px = longint'(col_sine[col]) * depth;
			py = longint'(row_sine[row]) * depth;
			if (py > longint'(sh_min_y) * 32768 && py < longint'(sh_max_y) * 32768 &&
					px > longint'(sh_min_x) * 32768 && px < longint'(sh_max_x) * 32768) begin
				// round half up: floor((px + 16384) / 32768)
				xmm = (px + 16384) >>> 15;
				frame_sum += xmm;
				if (frame_sum > 64'sd8589934591) frame_sum = 64'sd8589934591;
				if (frame_sum < -64'sd8589934592) frame_sum = -64'sd8589934592;
				if (frame_points < 1048575) frame_points++;
				if (depth < frame_nearest) frame_nearest = depth;
			end
		end
		if (!last)
			return;
		mean = 0;
		rate = 0;
		if (frame_points > 0) begin
			mean = frame_sum / longint'(frame_points);
			if (mean > 4095) mean = 4095;
			if (mean < -4096) mean = -4096;
		end
		if (frame_points > sh_min_pts) begin
			if (frame_nearest <= sh_near && !wait_flag) begin
				wait_flag = 1'b1;
				r.action = ACT_INVITE;
			end else if (frame_nearest > sh_far) begin
				wait_flag = 1'b0;
				r.action = ACT_FAR;
			end else begin
				r.action = ACT_TURN;
				rate = -mean * sh_gain;
				if (rate > 32767) rate = 32767;
				if (rate < -32768) rate = -32768;
			end
		end else begin
			r.action = ACT_FEW;
		end
		r.rate = rate[15:0];
		r.nearest = frame_nearest[15:0];
		r.mean = mean[12:0];
		r.points = frame_points[19:0];
		r.waiting = wait_flag;
		decision_queue.push_back(r);
		frame_sum = 0;
		frame_points = 0;
		frame_nearest = 65535;
	endfunction

	// send one transaction, idling at random before it; valid stays up until
	// the next transaction or the next drain replaces it
	task automatic send_item(input logic [1:0] cmd, input int col, input int row,
			input logic signed [15:0] sine, input int unsigned depth, input bit valid,
			input bit last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {1'b0, valid, depth[15:0], sine, row[9:0], col[9:0], cmd};
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_item(cmd, col, row, sine, depth, valid, last);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [19:0] value);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_MIN_X: sh_min_x = value[12:0];
			REG_MAX_X: sh_max_x = value[12:0];
			REG_MIN_Y: sh_min_y = value[12:0];
			REG_MAX_Y: sh_max_y = value[12:0];
			REG_NEAR:  sh_near = value[15:0];
			REG_FAR:   sh_far = value[15:0];
			REG_MINPT: sh_min_pts = value;
			REG_GAIN:  sh_gain = value[7:0];
			default: ;
		endcase
	endtask

	// stop sending, wait for every decision, then let the division pipe drain
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (decision_queue.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_box(input int mnx, input int mxx, input int mny, input int mxy);
		write_reg(REG_MIN_X, 20'(mnx));
		write_reg(REG_MAX_X, 20'(mxx));
		write_reg(REG_MIN_Y, 20'(mny));
		write_reg(REG_MAX_Y, 20'(mxy));
	endtask

	// pixel whose table entries were loaded; random in-range coordinates
	task automatic send_pixel(input bit last);
		int c, r;
		int unsigned d;
		c = $urandom_range(63);
		r = $urandom_range(63);
		case ($urandom_range(9))
			0: d = $urandom_range(65535);
			1: d = 0;
			default: d = $urandom_range(int'(sh_far) + 50);
		endcase
		if (d > 65535) d = 65535;
		send_item(CMD_PIXEL, c, r, 16'sd0, d, $urandom_range(9) != 0, last);
	endtask

	// load the first 64 entries of each table with small angles, plus extreme entries
	task automatic test_load_tables();
		for (int i = 0; i < 64; i++)
			send_item(CMD_COL_SIN, i, 0, 16'((i - 32) * 400), 0, 0, 0);
		for (int i = 0; i < 64; i++)
			send_item(CMD_ROW_SIN, i, 0, 16'(i * 300 - 2000), 0, 0, 0);
		// full-scale and extreme entries at the top of the tables
		send_item(CMD_COL_SIN, 1023, 0, 16'sh7fff, 0, 0, 0);
		send_item(CMD_ROW_SIN, 1023, 0, 16'sh8000, 0, 0, 0);
		send_item(CMD_COL_SIN, 1022, 0, 16'sh8000, 0, 0, 0);
		send_item(CMD_ROW_SIN, 1022, 0, 16'sh7fff, 0, 0, 0);
	endtask

	task automatic test_directed();
		// unknown command, with frame_last set, gives nothing
		send_item(2'd3, 1023, 1023, 16'sh7fff, 65535, 1, 1);
		// table load with frame_last does not close a frame
		send_item(CMD_COL_SIN, 5, 0, 16'((5 - 32) * 400), 0, 0, 1);
		// invalid depth, depth beyond far, zero depth, extreme coordinates
		send_item(CMD_PIXEL, 32, 20, 0, 1000, 0, 0);
		send_item(CMD_PIXEL, 32, 20, 0, 65535, 1, 0);
		send_item(CMD_PIXEL, 32, 20, 0, 0, 1, 0);
		send_item(CMD_PIXEL, 1023, 1023, 0, 1500, 1, 0);
		send_item(CMD_PIXEL, 1022, 1022, 0, 2000, 1, 0);
		// empty frame: few points, nearest all ones, mean zero
		send_item(CMD_PIXEL, 0, 0, 0, 1200, 1, 1);
		wait_drained();
		// low threshold so decisions come: invite, then turn twice while waiting
		write_reg(REG_MINPT, 20'd0);
		set_box(-4000, 4000, -4000, 4000);
		send_item(CMD_PIXEL, 40, 20, 0, 500, 1, 1);
		send_item(CMD_PIXEL, 20, 20, 0, 500, 1, 1);
		send_item(CMD_PIXEL, 50, 20, 0, 1500, 1, 1);
		wait_drained();
		write_reg(REG_FAR, 20'd65535);
		write_reg(REG_NEAR, 20'd100);
		send_item(CMD_PIXEL, 63, 63, 0, 65535, 1, 1);
		wait_drained();
		// maximum gain saturates the rate
		write_reg(REG_GAIN, 20'd255);
		send_item(CMD_PIXEL, 1023, 0, 0, 4000, 1, 0);
		send_item(CMD_PIXEL, 1022, 0, 0, 4000, 1, 1);
		send_item(CMD_PIXEL, 0, 0, 0, 3000, 1, 1);
		wait_drained();
	endtask

	// random frames under several settings and idling phases
	task automatic test_random_frames(input int frames, input int max_len);
		int len;
		for (int f = 0; f < frames; f++) begin
			len = $urandom_range(max_len, 1);
			for (int p = 0; p < len; p++) begin
				if ($urandom_range(19) == 0) begin
					// noise: unknown command or a table rewrite within the loaded range
					if ($urandom_range(1))
						send_item(2'd3, $urandom_range(1023), $urandom_range(1023),
							16'($urandom), $urandom_range(65535), $urandom_range(1),
							$urandom_range(1));
					else
						send_item(CMD_ROW_SIN, $urandom_range(63), 0,
							16'($urandom_range(8000) - 4000), 0, 0, 0);
				end
				send_pixel(p == len - 1);
			end
		end
	endtask

	task automatic random_config();
		int mnx, mny;
		mnx = $urandom_range(1000) - 900;
		mny = $urandom_range(1000) - 900;
		set_box(mnx, mnx + $urandom_range(1500, 50), mny, mny + $urandom_range(1500, 50));
		write_reg(REG_NEAR, 20'($urandom_range(1500)));
		write_reg(REG_FAR, 20'($urandom_range(3000, 500)));
		write_reg(REG_MINPT, 20'($urandom_range(4)));
		write_reg(REG_GAIN, 20'($urandom_range(255)));
	endtask

	task automatic test_back_pressure();
		// receiver holds off long while frames keep coming
		hold_off_cycles = 400;
		test_random_frames(8, 3);
		wait_drained();
		// three more short frames, then the sender waits until every decision is back
		test_random_frames(3, 4);
		wait_drained();
	endtask

	task automatic test_extreme_config();
		set_box(-4096, 4095, -4096, 4095);
		write_reg(REG_NEAR, 20'd65535);
		write_reg(REG_FAR, 20'd65535);
		write_reg(REG_MINPT, 20'hfffff);
		write_reg(REG_GAIN, 20'd0);
		test_random_frames(4, 6);
		wait_drained();
		set_box(0, 0, 0, 0);
		write_reg(REG_NEAR, 20'd0);
		write_reg(REG_FAR, 20'd0);
		write_reg(REG_MINPT, 20'd0);
		test_random_frames(4, 6);
		wait_drained();
	endtask

	// receiver: random stall plus an occasional long hold-off
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// result checker: compare each decision with the oldest prediction
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.action = m_axis_tdata[1:0];
			got.rate = m_axis_tdata[17:2];
			got.nearest = m_axis_tdata[33:18];
			got.mean = m_axis_tdata[46:34];
			got.points = m_axis_tdata[66:47];
			got.waiting = m_axis_tdata[67];
			decisions_seen++;
			if (decision_queue.size() == 0) begin
				report_mismatch("unexpected decision", got.action, -1);
			end else begin
				want = decision_queue.pop_front();
				if (got.action !== want.action)
					report_mismatch("action", got.action, want.action);
				if (got.rate !== want.rate)
					report_mismatch("angular_rate_mrad", got.rate, want.rate);
				if (got.nearest !== want.nearest)
					report_mismatch("nearest_mm", got.nearest, want.nearest);
				if (got.mean !== want.mean)
					report_mismatch("mean_offset_mm", got.mean, want.mean);
				if (got.points !== want.points)
					report_mismatch("points_in_box", got.points, want.points);
				if (got.waiting !== want.waiting)
					report_mismatch("waiting", got.waiting, want.waiting);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CycleLimit) begin
			$display("depth_box_centroid_steer_core verification failed");
			$finish;
		end
	end

	initial begin
		cycle_count = 0;
		error_count = 0;
		decisions_seen = 0;
		hold_off_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		shadow_reset();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_load_tables();
		test_directed();
		test_extreme_config();

		// idling phases: none, sender, receiver, both
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1) ? 46 : (ph == 3) ? 12 : 0;
			recv_stall_pct = (ph == 2) ? 46 : (ph == 3) ? 12 : 0;
			for (int k = 0; k < 3; k++) begin
				random_config();
				test_random_frames(20, 12);
				wait_drained();
			end
		end
		test_back_pressure();
		wait_drained();

		if (error_count == 0)
			$display("depth_box_centroid_steer_core verification clean");
		else
			$display("depth_box_centroid_steer_core verification failed");
		$finish;
	end
endmodule
`default_nettype wire

[depth_box_centroid_steer_core.f]
rtl/dbcs_pkg.sv
rtl/dbcs_datapath.sv
rtl/dbcs_ctrl.sv
rtl/depth_box_centroid_steer_core.sv
test/tb_top.sv
